// File: rtl/lpgi_pkg.sv
// ----------------------------------------------------------------------------
// lpgi_pkg: shared constants for the line pixel gradient interpolator
// Holds lane numbering, channel constants and the default coordinate width.
// ----------------------------------------------------------------------------
package lpgi_pkg;

    localparam int DEFAULT_COORD_BITS = 16;
    localparam int NUM_LANES          = 4;
    localparam int CHAN_BITS          = 8;
    localparam int COLOR_BITS         = 24;

    // lane order through the divider chain
    localparam int LANE_Y     = 0;
    localparam int LANE_RED   = 1;
    localparam int LANE_GREEN = 2;
    localparam int LANE_BLUE  = 3;

    localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;

endpackage

// File: rtl/line_pixel_gradient_interp_unit.sv
// ----------------------------------------------------------------------------
// line_pixel_gradient_interp_unit: segment y and color gradient at one x
// Returns y and the RGB color of a straight segment at a given pixel x.
// ----------------------------------------------------------------------------
// One request per clock is taken and one result per clock is delivered while
// the output is not stalled. The pipeline has an input register, a subtract and
// multiply stage, a chain of 2*COORD_BITS+1 division cells (one quotient bit
// each, with the y lane and the three color lanes sharing the span as
// divisor, and the magnitudes formed in front of the first cell), and an
// output register. The whole pipeline advances
// whenever the output register is empty or being taken. y is start_y plus
// (end_y-start_y)*dx/span truncated toward zero and saturated to the signed
// coordinate range; each color channel is c0 + floor((c1-c0)*dx/span) clamped
// to 0..255. A zero span returns zero_span in tuser with y and color zero.
// ----------------------------------------------------------------------------
module line_pixel_gradient_interp_unit #(
    parameter int COORD_BITS = lpgi_pkg::DEFAULT_COORD_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // start_x, start_y, end_x, end_y (COORD_BITS each), start_color (24),
    // end_color (24), pixel_x (COORD_BITS), zero padding to bytes
    input  logic [((5*COORD_BITS+48+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // pixel_y (COORD_BITS), pixel_color (24), zero padding to bytes
    output logic [((COORD_BITS+24+7)/8)*8-1:0]   m_axis_tdata,
    // zero_span
    output logic m_axis_tuser
);
    import lpgi_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;             // span magnitude width
    localparam int NW  = 2*C + 1;           // product magnitude / quotient width
    localparam int PW  = 2*C + 2;           // signed product width
    localparam int CPW = C + CHAN_BITS + 2; // signed color product width
    localparam int SW  = 1 + C + COLOR_BITS + NUM_LANES;
    localparam int ODW = ((C+24+7)/8)*8;

    // advance everything when the output slot is free or being taken
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- input register ----------------
    logic                   r0_v;
    logic signed [C-1:0]    r0_x0, r0_y0, r0_x1, r0_y1, r0_px;
    logic [COLOR_BITS-1:0]  r0_c0, r0_c1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_x0 <= s_axis_tdata[C-1:0];
            r0_y0 <= s_axis_tdata[2*C-1:C];
            r0_x1 <= s_axis_tdata[3*C-1:2*C];
            r0_y1 <= s_axis_tdata[4*C-1:3*C];
            r0_c0 <= s_axis_tdata[4*C+23:4*C];
            r0_c1 <= s_axis_tdata[4*C+47:4*C+24];
            r0_px <= s_axis_tdata[5*C+47:4*C+48];
        end
    end

    // ---------------- differences and products ----------------
    logic signed [C:0]     span, dx, dy;
    logic signed [PW-1:0]  n_prod [NUM_LANES];

    assign span = {r0_x1[C-1], r0_x1} - {r0_x0[C-1], r0_x0};
    assign dx   = {r0_px[C-1], r0_px} - {r0_x0[C-1], r0_x0};
    assign dy   = {r0_y1[C-1], r0_y1} - {r0_y0[C-1], r0_y0};

    always_comb begin
        logic signed [CHAN_BITS:0] cd;
        logic signed [CPW-1:0] cp;
        n_prod[LANE_Y] = PW'(dy) * PW'(dx);
        for (int k = 1; k < NUM_LANES; k++) begin
            cd = $signed({1'b0, r0_c1[(NUM_LANES-1-k)*CHAN_BITS +: CHAN_BITS]})
               - $signed({1'b0, r0_c0[(NUM_LANES-1-k)*CHAN_BITS +: CHAN_BITS]});
            cp = CPW'(cd) * CPW'(dx);
            n_prod[k] = PW'(cp);
        end
    end

    logic                   r1_v;
    logic signed [PW-1:0]   r1_prod [NUM_LANES];
    logic signed [C:0]      r1_span;
    logic [C-1:0]           r1_y0;
    logic [COLOR_BITS-1:0]  r1_c0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod <= n_prod;
            r1_span <= span;
            r1_y0   <= r0_y0;
            r1_c0   <= r0_c0;
        end
    end

    // ---------------- magnitudes and quotient signs ----------------
    logic [DW-1:0]     d_mag;
    logic [DW+NW-1:0]  acc0 [NUM_LANES];
    logic [NUM_LANES-1:0] neg;
    logic [SW-1:0]     side0;

    assign d_mag = r1_span[C] ? DW'(-r1_span) : DW'(r1_span);

    always_comb begin
        logic [PW-1:0] m;
        for (int k = 0; k < NUM_LANES; k++) begin
            m       = r1_prod[k][PW-1] ? PW'(-r1_prod[k]) : PW'(r1_prod[k]);
            acc0[k] = {{DW{1'b0}}, m[NW-1:0]};
            neg[k]  = r1_prod[k][PW-1] ^ r1_span[C];
        end
    end

    // sideband: zero_span, y0, start color, quotient signs
    assign side0 = {neg, r1_c0, r1_y0, (r1_span == '0)};

    // ---------------- division chain ----------------
    logic              c_v    [NW+1];
    logic [DW-1:0]     c_d    [NW+1];
    logic [DW+NW-1:0]  c_acc  [NW+1][NUM_LANES];
    logic [SW-1:0]     c_side [NW+1];

    assign c_v[0]    = r1_v;
    assign c_d[0]    = d_mag;
    assign c_acc[0]  = acc0;
    assign c_side[0] = side0;

    for (genvar i = 0; i < NW; i++) begin : g_cell
        lpgi_div_cell #(.DW(DW), .NW(NW), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_v[i]),
            .i_d     (c_d[i]),
            .i_acc   (c_acc[i]),
            .i_side  (c_side[i]),
            .o_valid (c_v[i+1]),
            .o_d     (c_d[i+1]),
            .o_acc   (c_acc[i+1]),
            .o_side  (c_side[i+1])
        );
    end

    // ---------------- sign, offset and saturate ----------------
    logic                  f_zero;
    logic signed [C-1:0]   f_y0;
    logic [COLOR_BITS-1:0] f_c0;
    logic [NUM_LANES-1:0]  f_neg;
    logic [C-1:0]          n_y;
    logic [COLOR_BITS-1:0] n_color;

    assign f_zero = c_side[NW][0];
    assign f_y0   = c_side[NW][C:1];
    assign f_c0   = c_side[NW][C+COLOR_BITS:C+1];
    assign f_neg  = c_side[NW][SW-1:C+COLOR_BITS+1];

    localparam logic signed [NW+1:0] YMAX = (NW+2)'((64'sd1 <<< (C-1)) - 1);
    localparam logic signed [NW+1:0] YMIN = -YMAX - 1;

    always_comb begin
        logic [NW-1:0]          q;
        logic [DW-1:0]          rem;
        logic signed [NW:0]     qy;
        logic signed [NW+1:0]   ysum;
        logic [NW:0]            qa;
        logic signed [NW+1:0]   qc;
        logic signed [NW+2:0]   v;
        logic [CHAN_BITS-1:0]   a;
        q    = c_acc[NW][LANE_Y][NW-1:0];
        qy   = f_neg[LANE_Y] ? -$signed({1'b0, q}) : $signed({1'b0, q});
        ysum = {{(NW+2-C){f_y0[C-1]}}, f_y0} + {qy[NW], qy};
        priority if (ysum > YMAX) begin
            n_y = YMAX[C-1:0];
        end else if (ysum < YMIN) begin
            n_y = YMIN[C-1:0];
        end else begin
            n_y = ysum[C-1:0];
        end
        n_color = '0;
        for (int k = 1; k < NUM_LANES; k++) begin
            q   = c_acc[NW][k][NW-1:0];
            rem = c_acc[NW][k][DW+NW-1:NW];
            qa  = {1'b0, q} + (NW+1)'(f_neg[k] && (rem != '0));
            qc  = f_neg[k] ? -$signed({1'b0, qa}) : $signed({1'b0, qa});
            a   = f_c0[(NUM_LANES-1-k)*CHAN_BITS +: CHAN_BITS];
            v   = $signed({{(NW+3-CHAN_BITS){1'b0}}, a}) + {qc[NW+1], qc};
            priority if (v[NW+2]) begin
                n_color[(NUM_LANES-1-k)*CHAN_BITS +: CHAN_BITS] = '0;
            end else if (v > $signed((NW+3)'(CHAN_MAX))) begin
                n_color[(NUM_LANES-1-k)*CHAN_BITS +: CHAN_BITS] = CHAN_MAX;
            end else begin
                n_color[(NUM_LANES-1-k)*CHAN_BITS +: CHAN_BITS] = v[CHAN_BITS-1:0];
            end
        end
        if (f_zero) begin
            n_y     = '0;
            n_color = '0;
        end
    end

    // ---------------- output register ----------------
    logic [C-1:0]          r_y;
    logic [COLOR_BITS-1:0] r_color;
    logic                  r_zero;
    logic                  r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= c_v[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_y     <= n_y;
            r_color <= n_color;
            r_zero  <= f_zero;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = ODW'({r_color, r_y});
    assign m_axis_tuser  = r_zero;

endmodule

// File: rtl/lpgi_div_cell.sv
// ----------------------------------------------------------------------------
// lpgi_div_cell: one restoring-division step for all lanes
// Shifts each lane's remainder/quotient word left by one, subtracts the
// shared divisor where it fits and sets the quotient bit.
// ----------------------------------------------------------------------------
module lpgi_div_cell #(
    parameter int DW = 17,   // divisor width
    parameter int NW = 33,   // dividend / quotient width
    parameter int SW = 45    // sideband width
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [DW-1:0]         i_d,
    input  logic [DW+NW-1:0]      i_acc [lpgi_pkg::NUM_LANES],
    input  logic [SW-1:0]         i_side,
    output logic                  o_valid,
    output logic [DW-1:0]         o_d,
    output logic [DW+NW-1:0]      o_acc [lpgi_pkg::NUM_LANES],
    output logic [SW-1:0]         o_side
);
    import lpgi_pkg::*;

    logic                 r_valid;
    logic [DW-1:0]        r_d;
    logic [DW+NW-1:0]     r_acc [NUM_LANES];
    logic [SW-1:0]        r_side;
    logic [DW+NW-1:0]     n_acc [NUM_LANES];

    always_comb begin
        logic [DW:0] hi;
        for (int k = 0; k < NUM_LANES; k++) begin
            hi = i_acc[k][DW+NW-1:NW-1];
            if (hi >= {1'b0, i_d}) begin
                hi = hi - {1'b0, i_d};
                n_acc[k] = {hi[DW-1:0], i_acc[k][NW-2:0], 1'b1};
            end else begin
                n_acc[k] = {hi[DW-1:0], i_acc[k][NW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d    <= i_d;
            r_acc  <= n_acc;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
    assign o_acc   = r_acc;
    assign o_side  = r_side;

endmodule
